[rtl/serial_binary_upload_receiver_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the serial upload receiver
// Concurrent property wrappers clocked on clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_BINARY_UPLOAD_RECEIVER_ASSERT_SVH
`define SERIAL_BINARY_UPLOAD_RECEIVER_ASSERT_SVH

// Same-cycle implication.
`define SBUR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbur assertion failed");

// Next-cycle implication.
`define SBUR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbur assertion failed");

`endif

[rtl/sbur_pkg.sv]
// ----------------------------------------------------------------------------
// Serial upload receiver package
// Shared constants, register codes, event codes and the result beat type.
// ----------------------------------------------------------------------------
package sbur_pkg;

    localparam logic [31:0] CMD_MAIN   = 32'h4241_524D;
    localparam logic [31:0] CMD_SECOND = 32'h4250_5043;

    localparam logic [31:0] TIMEOUT_RESET     = 32'd5000;
    localparam logic [31:0] MAX_LENGTH_RESET  = 32'd20 * 32'd1024 * 32'd1024;
    localparam logic [31:0] MAIN_BASE_RESET   = 32'h0000_0000;
    localparam logic [31:0] SECOND_BASE_RESET = 32'h1010_0000;

    localparam int RES_DEPTH = 4;
    localparam int RES_AW    = $clog2(RES_DEPTH);

    typedef enum logic [2:0] {
        REG_ENABLED     = 3'd0,
        REG_TIMEOUT     = 3'd1,
        REG_MAX_LENGTH  = 3'd2,
        REG_MAIN_BASE   = 3'd3,
        REG_SECOND_BASE = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        EV_WRITE    = 2'd0,
        EV_LENGTH   = 2'd1,
        EV_COMPLETE = 2'd2,
        EV_ABORT    = 2'd3
    } event_t;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic CAUSE_TIMEOUT = 1'b0;
    localparam logic CAUSE_LENGTH  = 1'b1;

    typedef struct packed {
        logic        enabled;
        logic [31:0] timeout_ticks;
        logic [31:0] max_length;
        logic [31:0] main_cpu_base;
        logic [31:0] second_cpu_base;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [31:0] write_address;
        logic [7:0]  write_data;
        logic        target;
        logic [31:0] payload_length;
        logic        abort_cause;
        logic        last;
    } res_t;

    // Up to two results leave the core for one input beat.
    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } push_t;

    function automatic res_t make_result(event_t ev, logic [31:0] addr,
                                         logic [7:0] data, logic cause);
        res_t r;
        r                = '0;
        r.event_res      = ev;
        r.write_address  = addr;
        r.write_data     = data;
        r.abort_cause    = cause;
        return r;
    endfunction

endpackage

[rtl/sbur_in_if.sv]
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one received byte or one timer tick per beat.
// ----------------------------------------------------------------------------
interface sbur_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

[rtl/sbur_out_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one receiver event per beat.
// ----------------------------------------------------------------------------
interface sbur_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [31:0] write_address;
    logic [7:0]  write_data;
    logic        target;
    logic [31:0] payload_length;
    logic        abort_cause;
    logic        last;

    modport source (output valid, output event_res, output write_address,
                    output write_data, output target, output payload_length,
                    output abort_cause, output last, input ready);
    modport sink   (input valid, input event_res, input write_address,
                    input write_data, input target, input payload_length,
                    input abort_cause, input last, output ready);
endinterface

[rtl/sbur_regs.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// Write-only register file for enable, timeout, length limit and load bases.
// ----------------------------------------------------------------------------
module sbur_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output sbur_pkg::cfg_t     cfg
);
    import sbur_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENABLED:     cfg_next.enabled         = cfg_data[0];
                REG_TIMEOUT:     cfg_next.timeout_ticks   = cfg_data;
                REG_MAX_LENGTH:  cfg_next.max_length      = cfg_data;
                REG_MAIN_BASE:   cfg_next.main_cpu_base   = cfg_data;
                REG_SECOND_BASE: cfg_next.second_cpu_base = cfg_data;
                default:         cfg_next                 = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled         <= 1'b0;
            cfg_reg.timeout_ticks   <= TIMEOUT_RESET;
            cfg_reg.max_length      <= MAX_LENGTH_RESET;
            cfg_reg.main_cpu_base   <= MAIN_BASE_RESET;
            cfg_reg.second_cpu_base <= SECOND_BASE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/sbur_core.sv]
// ----------------------------------------------------------------------------
// Upload sequencer core
// Input register, command/length/payload sequencer and result generation.
// ----------------------------------------------------------------------------
module sbur_core (
    input  logic               clk,
    input  logic               rst_n,
    sbur_in_if.sink            in_ch,
    input  sbur_pkg::cfg_t     cfg,
    input  logic               room,
    output sbur_pkg::push_t    push
);
    import sbur_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SIZE = 2'd1,
        PH_LOAD = 2'd2
    } phase_t;

    // Input register.
    logic       pend_valid_reg, pend_valid_next;
    logic       pend_kind_reg;
    logic [7:0] pend_byte_reg;

    // Sequencer state.
    phase_t      phase_reg, phase_next;
    logic [31:0] window_reg, window_next;
    logic [2:0]  size_left_reg, size_left_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [31:0] address_reg, address_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic        timer_reg, timer_next;
    logic        target_reg, target_next;

    logic        accept;
    logic        advance;
    logic        finish;
    logic [31:0] tick_count;
    logic [31:0] length_shift;
    logic [31:0] window_shift;
    logic [2:0]  size_dec;
    logic [31:0] remaining_dec;
    res_t        res0, res1;
    logic [1:0]  res_count;

    assign in_ch.ready = !pend_valid_reg || room;
    assign accept      = in_ch.valid && in_ch.ready;
    assign advance     = pend_valid_reg && room;

    assign tick_count    = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 32'd1;
    assign length_shift  = {length_reg[23:0], pend_byte_reg};
    assign window_shift  = {window_reg[23:0], pend_byte_reg};
    assign size_dec      = size_left_reg - 3'd1;
    assign remaining_dec = remaining_reg - 32'd1;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (accept)
        begin
            pend_valid_next = 1'b1;
        end
        else if (advance)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        window_next    = window_reg;
        size_left_next = size_left_reg;
        length_next    = length_reg;
        remaining_next = remaining_reg;
        address_next   = address_reg;
        elapsed_next   = elapsed_reg;
        timer_next     = timer_reg;
        target_next    = target_reg;
        finish         = 1'b0;
        res0           = '0;
        res1           = '0;
        res_count      = 2'd0;

        if (advance && cfg.enabled)
        begin
            if (pend_kind_reg == KIND_TICK)
            begin
                if (timer_reg)
                begin
                    elapsed_next = tick_count;
                    if (tick_count > cfg.timeout_ticks)
                    begin
                        res0      = make_result(EV_ABORT, '0, '0, CAUSE_TIMEOUT);
                        res_count = 2'd1;
                        finish    = 1'b1;
                    end
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_SIZE:
                    begin
                        length_next    = length_shift;
                        size_left_next = size_dec;
                        if (size_dec == 3'd0)
                        begin
                            if (length_shift > cfg.max_length)
                            begin
                                res0      = make_result(EV_ABORT, '0, '0, CAUSE_LENGTH);
                                res_count = 2'd1;
                                finish    = 1'b1;
                            end
                            else
                            begin
                                res0           = make_result(EV_LENGTH, '0, '0, 1'b0);
                                res_count      = 2'd1;
                                remaining_next = length_shift;
                                phase_next     = PH_LOAD;
                                if (length_shift == 32'd0)
                                begin
                                    res1      = make_result(EV_COMPLETE, '0, '0, 1'b0);
                                    res_count = 2'd2;
                                    finish    = 1'b1;
                                end
                            end
                        end
                    end
                    PH_LOAD:
                    begin
                        res0           = make_result(EV_WRITE, address_reg,
                                                     pend_byte_reg, 1'b0);
                        res_count      = 2'd1;
                        address_next   = address_reg + 32'd1;
                        remaining_next = remaining_dec;
                        if (remaining_dec == 32'd0)
                        begin
                            res1      = make_result(EV_COMPLETE, '0, '0, 1'b0);
                            res_count = 2'd2;
                            finish    = 1'b1;
                        end
                    end
                    default:
                    begin
                        // Idle and the unused phase code both hunt for a command.
                        phase_next  = PH_IDLE;
                        window_next = window_shift;
                        if (window_shift == CMD_MAIN || window_shift == CMD_SECOND)
                        begin
                            target_next    = (window_shift == CMD_SECOND);
                            address_next   = (window_shift == CMD_SECOND)
                                           ? cfg.second_cpu_base : cfg.main_cpu_base;
                            phase_next     = PH_SIZE;
                            size_left_next = 3'd4;
                            length_next    = '0;
                            remaining_next = '0;
                            elapsed_next   = '0;
                            timer_next     = 1'b1;
                        end
                    end
                endcase
            end

            if (finish)
            begin
                window_next    = '0;
                phase_next     = PH_IDLE;
                size_left_next = '0;
                remaining_next = '0;
                elapsed_next   = '0;
                timer_next     = 1'b0;
            end
        end

        res0.target         = target_next;
        res0.payload_length = length_next;
        res1.target         = target_next;
        res1.payload_length = length_next;
        res0.last           = (res_count == 2'd1);
        res1.last           = (res_count == 2'd2);
    end

    assign push.count  = res_count;
    assign push.first  = res0;
    assign push.second = res1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            phase_reg      <= PH_IDLE;
            window_reg     <= '0;
            size_left_reg  <= '0;
            length_reg     <= '0;
            remaining_reg  <= '0;
            address_reg    <= '0;
            elapsed_reg    <= '0;
            timer_reg      <= 1'b0;
            target_reg     <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            phase_reg      <= phase_next;
            window_reg     <= window_next;
            size_left_reg  <= size_left_next;
            length_reg     <= length_next;
            remaining_reg  <= remaining_next;
            address_reg    <= address_next;
            elapsed_reg    <= elapsed_next;
            timer_reg      <= timer_next;
            target_reg     <= target_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_kind_reg <= in_ch.kind;
            pend_byte_reg <= in_ch.rx_byte;
        end
    end

endmodule

[rtl/sbur_fifo.sv]
// ----------------------------------------------------------------------------
// Result queue
// Small queue taking up to two results per cycle and releasing one per beat.
// ----------------------------------------------------------------------------
`include "serial_binary_upload_receiver_assert.svh"

module sbur_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  sbur_pkg::push_t    push,
    output logic               room,
    sbur_out_if.source         out_ch
);
    import sbur_pkg::*;

    res_t              mem [RES_DEPTH];
    logic [RES_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_AW:0]   count_reg, count_next;
    logic              pop;
    logic [RES_AW-1:0] wr_ptr_inc;
    res_t              head;

    assign wr_ptr_inc = wr_ptr_reg + 1'b1;
    assign pop        = out_ch.valid && out_ch.ready;
    // Room for the worst case of two results from one input beat.
    assign room       = (count_reg <= (RES_AW + 1)'(RES_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + push.count[RES_AW-1:0];
    assign rd_ptr_next = rd_ptr_reg + {{(RES_AW - 1){1'b0}}, pop};
    assign count_next  = count_reg + (RES_AW + 1)'(push.count)
                       - (RES_AW + 1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_inc] <= push.second;
        end
    end

    assign head = mem[rd_ptr_reg];

    assign out_ch.valid          = (count_reg != '0);
    assign out_ch.event_res      = head.event_res;
    assign out_ch.write_address  = head.write_address;
    assign out_ch.write_data     = head.write_data;
    assign out_ch.target         = head.target;
    assign out_ch.payload_length = head.payload_length;
    assign out_ch.abort_cause    = head.abort_cause;
    assign out_ch.last           = head.last;

    `SBUR_ASSERT_NOW(a_no_overflow, 1'b1, count_reg <= (RES_AW + 1)'(RES_DEPTH))
    `SBUR_ASSERT_NOW(a_push_has_room, push.count != 2'd0, room)
    `SBUR_ASSERT_NEXT(a_pop_only, pop && push.count == 2'd0,
                      count_reg == $past(count_reg) - 1'b1)

endmodule

[rtl/serial_binary_upload_receiver.sv]
// ----------------------------------------------------------------------------
// Serial binary upload receiver
// Detects an upload command in the received byte stream, collects a
// big-endian length and turns the payload into addressed byte writes.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Beat contents
//   in_ch     sink       kind (byte or timer tick), rx_byte
//   out_ch    source     event_res, write_address, write_data, target,
//                        payload_length, abort_cause, last
//   cfg_*     write      register index and 32-bit data, no read-back
//
// Each beat waits in the input register until the queue has room; it is then
// processed and its results are written into the queue that feeds out_ch.
// A beat is taken every cycle while the queue holds at most two results; a
// beat with two results (last payload byte or zero length) is sent as two beats.
// Reset clears the sequencer and queue and loads the register defaults. Once
// three results wait on a stalled out_ch, in_ch.ready drops behind the held beat.
//
// While idle the receiver shifts bytes into a 32-bit window and compares it
// against the two command words. A match selects the target image and its
// load base and starts the tick timer. Four length bytes follow, most
// significant first; the length is compared against max_length. Payload
// bytes then produce writes at incrementing addresses, and the final one is
// followed by a load complete event. Ticks beyond timeout_ticks abort the
// upload. With enabled low, beats are consumed and all state holds.
// ----------------------------------------------------------------------------
module serial_binary_upload_receiver (
    input  logic        clk,
    input  logic        rst_n,
    sbur_in_if.sink     in_ch,
    sbur_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import sbur_pkg::*;

    cfg_t  cfg;
    push_t push;
    logic  room;

    // Configuration register file.
    sbur_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register and sequencer; hands up to two results per beat.
    sbur_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .cfg   (cfg),
        .room  (room),
        .push  (push)
    );

    // Result queue that decouples the sequencer from output stalls.
    sbur_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .out_ch (out_ch)
    );

endmodule
